// File: sv/lzo_pkg.sv
// ----------------------------------------------------------------------------
// LZO1X decompressor package
// Shared types, codes and helpers of the stream decompressor.
// ----------------------------------------------------------------------------
package lzo_pkg;

	localparam int WINDOW_BYTES_DEF = 65536;
	localparam int QUEUE_DEPTH      = 4;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FORMAT     = 3'd1,
		ST_OVERRUN    = 3'd2,
		ST_LOOKBEHIND = 3'd3,
		ST_REFUSED    = 3'd4
	} status_t;

	typedef enum logic [13:0] {
		PH_FIRST       = 14'b00000000000001,
		PH_TOP         = 14'b00000000000010,
		PH_LEN_EXT     = 14'b00000000000100,
		PH_LIT         = 14'b00000000001000,
		PH_AFTER_LIT   = 14'b00000000010000,
		PH_AFTER_MATCH = 14'b00000000100000,
		PH_M1L_DIST    = 14'b00000001000000,
		PH_M1_DIST     = 14'b00000010000000,
		PH_M2_DIST     = 14'b00000100000000,
		PH_D0          = 14'b00001000000000,
		PH_D1          = 14'b00010000000000,
		PH_COPY        = 14'b00100000000000,
		PH_TRAIL       = 14'b01000000000000,
		PH_DONE        = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic        put;
		logic        copy;
		logic [7:0]  data;
		logic        copy_pending;
		logic        finished;
		status_t     status;
		logic [23:0] consumed;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	function automatic logic [23:0] sat24(input logic [24:0] s);
		return s[24] ? 24'hFFFFFF : s[23:0];
	endfunction

endpackage

// File: sv/lzo_ifs.sv
// ----------------------------------------------------------------------------
// LZO1X decompressor channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface lzo_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;
	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface lzo_out_if;
	logic        valid;
	logic        ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        copy_pending;
	logic        finished;
	logic [2:0]  status;
	logic [23:0] consumed;
	modport source (output valid, output out_valid, output out_byte, output copy_pending,
		output finished, output status, output consumed, input ready);
	modport sink (input valid, input out_valid, input out_byte, input copy_pending,
		input finished, input status, input consumed, output ready);
endinterface

// File: sv/lzo_ram.sv
// ----------------------------------------------------------------------------
// LZO1X generic RAM
// Single write port, single registered read port, read returns old data.
// ----------------------------------------------------------------------------
module lzo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/lzo_front.sv
// ----------------------------------------------------------------------------
// LZO1X front end
// Parses compressed words, keeps all control state, issues result commands.
// ----------------------------------------------------------------------------
module lzo_front #(
	parameter int WINDOW_BYTES = lzo_pkg::WINDOW_BYTES_DEF,
	localparam int AW = $clog2(WINDOW_BYTES)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [23:0]    out_limit,
	lzo_in_if.sink         in_ch,
	input  logic           q_full,
	output logic           q_push,
	output lzo_pkg::cmd_t  cmd,
	output logic [AW-1:0]  src,
	output logic [AW-1:0]  wa
);

	lzo_pkg::phase_t  ph_q, n_ph;
	lzo_pkg::status_t sticky_q, n_sticky;
	logic [23:0] oc_q, n_oc, in_q, n_in, run_q, n_run, room, room_p, lc, rl;
	logic [15:0] md_q, n_md;
	logic [1:0]  trail_q, n_trail, sm_tr;
	logic [7:0]  instr_q, n_instr, b, d8, incr;
	logic [AW-1:0] wr_q, n_wr;
	logic [AW:0]   diff;
	logic [16:0] sm_dist, dd;
	logic [23:0] sm_len;
	logic        active, refused, put, copy, do_top, do_dm, do_sm;

	assign b      = in_ch.data_byte;
	assign in_ch.ready = !q_full;
	assign q_push = in_ch.valid && !q_full;
	assign active = (sticky_q == lzo_pkg::ST_OK) && (ph_q != lzo_pkg::PH_DONE);
	assign room   = (out_limit > oc_q) ? out_limit - oc_q : 24'd0;
	assign room_p = (room == 24'd0) ? 24'd0 : room - 24'd1;
	assign diff   = {1'b0, wr_q} - (AW+1)'(md_q);
	assign src    = diff[AW] ? AW'(diff + (AW+1)'(WINDOW_BYTES)) : diff[AW-1:0];
	assign wa     = wr_q;

	always_comb begin
		n_ph = ph_q; n_sticky = sticky_q; n_oc = oc_q; n_in = in_q; n_run = run_q;
		n_md = md_q; n_trail = trail_q; n_instr = instr_q; n_wr = wr_q;
		refused = 1'b0; put = 1'b0; copy = 1'b0;
		do_top = 1'b0; do_dm = 1'b0; do_sm = 1'b0;
		sm_dist = '0; sm_len = '0; sm_tr = '0; d8 = '0; incr = '0; lc = '0; rl = '0;
		dd = '0;
		if (active) begin
			if (!in_ch.opcode) begin
				if (ph_q == lzo_pkg::PH_COPY) begin
					refused = 1'b1;
				end else begin
					n_in = lzo_pkg::sat24({1'b0, in_q} + 25'd1);
					case (ph_q)
						lzo_pkg::PH_FIRST: begin
							if (b > 8'd17) begin
								d8 = b - 8'd17;
								if (d8 < 8'd4) begin
									n_trail = d8[1:0];
									n_run = '0;
									if (24'(d8) > room) n_sticky = lzo_pkg::ST_OVERRUN;
									else n_ph = lzo_pkg::PH_TRAIL;
								end else if (24'(d8) > room) begin
									n_sticky = lzo_pkg::ST_OVERRUN;
								end else begin
									n_run = 24'(d8);
									n_ph = lzo_pkg::PH_LIT;
								end
							end else begin
								do_top = 1'b1;
							end
						end
						lzo_pkg::PH_TOP: do_top = 1'b1;
						lzo_pkg::PH_LEN_EXT: begin
							if (b == 8'd0) begin
								n_run = lzo_pkg::sat24({1'b0, run_q} + 25'd255);
							end else begin
								incr = (instr_q >= 8'd32) ? 8'd31 :
									((instr_q >= 8'd16) ? 8'd7 : 8'd15);
								rl = lzo_pkg::sat24({1'b0, run_q} + 25'(incr) + 25'(b));
								n_run = rl;
								if (instr_q < 8'd16) begin
									lc = lzo_pkg::sat24({1'b0, rl} + 25'd3);
									if (lc > room) begin
										n_sticky = lzo_pkg::ST_OVERRUN;
									end else begin
										n_run = lc;
										n_ph = lzo_pkg::PH_AFTER_LIT;
									end
								end else begin
									n_ph = lzo_pkg::PH_D0;
								end
							end
						end
						lzo_pkg::PH_LIT: begin
							put = 1'b1;
							n_run = run_q - 24'd1;
							if (n_run == 24'd0) n_ph = lzo_pkg::PH_AFTER_LIT;
						end
						lzo_pkg::PH_AFTER_LIT: begin
							if (b >= 8'd16) begin
								do_dm = 1'b1;
							end else begin
								n_instr = b;
								n_ph = lzo_pkg::PH_M1L_DIST;
							end
						end
						lzo_pkg::PH_AFTER_MATCH: begin
							if (b >= 8'd16) begin
								do_dm = 1'b1;
							end else begin
								n_instr = b;
								n_ph = lzo_pkg::PH_M1_DIST;
							end
						end
						lzo_pkg::PH_M1L_DIST: begin
							do_sm = 1'b1;
							sm_dist = 17'd1 + 17'h00800 + 17'(instr_q[7:2]) + 17'({b, 2'b00});
							sm_len = 24'd3;
							sm_tr = instr_q[1:0];
						end
						lzo_pkg::PH_M1_DIST: begin
							do_sm = 1'b1;
							sm_dist = 17'd1 + 17'(instr_q[7:2]) + 17'({b, 2'b00});
							sm_len = 24'd2;
							sm_tr = instr_q[1:0];
						end
						lzo_pkg::PH_M2_DIST: begin
							do_sm = 1'b1;
							sm_dist = 17'd1 + 17'(instr_q[4:2]) + 17'({b, 3'b000});
							sm_len = 24'(instr_q[7:5]) + 24'd1;
							sm_tr = instr_q[1:0];
						end
						lzo_pkg::PH_D0: begin
							n_md = 16'(b[7:2]);
							n_trail = b[1:0];
							n_ph = lzo_pkg::PH_D1;
						end
						lzo_pkg::PH_D1: begin
							dd = 17'(md_q[5:0]) + 17'({b, 6'b000000});
							sm_len = lzo_pkg::sat24({1'b0, run_q} + 25'd2);
							sm_tr = trail_q;
							if (instr_q >= 8'd32) begin
								do_sm = 1'b1;
								sm_dist = dd + 17'd1;
							end else begin
								dd = dd + (instr_q[3] ? 17'h04000 : 17'd0);
								if (dd == 17'd0) begin
									if (run_q != 24'd1) n_sticky = lzo_pkg::ST_FORMAT;
									else if (oc_q != out_limit) n_sticky = lzo_pkg::ST_LOOKBEHIND;
									else n_ph = lzo_pkg::PH_DONE;
								end else begin
									do_sm = 1'b1;
									sm_dist = dd + 17'h04000;
								end
							end
						end
						lzo_pkg::PH_TRAIL: begin
							put = 1'b1;
							n_trail = trail_q - 2'd1;
							if (n_trail == 2'd0) n_ph = lzo_pkg::PH_AFTER_MATCH;
						end
						default: ;
					endcase
					if (do_top) begin
						if (b >= 8'd16) begin
							do_dm = 1'b1;
						end else if (b == 8'd0) begin
							n_instr = '0;
							n_run = '0;
							n_ph = lzo_pkg::PH_LEN_EXT;
						end else if (24'(b) + 24'd3 > room) begin
							n_sticky = lzo_pkg::ST_OVERRUN;
						end else begin
							n_run = 24'(b) + 24'd3;
							n_ph = lzo_pkg::PH_LIT;
						end
					end
					if (do_dm) begin
						n_instr = b;
						if (b >= 8'd64) begin
							n_ph = lzo_pkg::PH_M2_DIST;
						end else begin
							n_run = (b >= 8'd32) ? 24'(b[4:0]) : 24'(b[2:0]);
							n_ph = (n_run == 24'd0) ? lzo_pkg::PH_LEN_EXT : lzo_pkg::PH_D0;
						end
					end
					if (do_sm) begin
						if (sm_dist == 17'd0 || 24'(sm_dist) > oc_q ||
							sm_dist > 17'(WINDOW_BYTES)) begin
							n_sticky = lzo_pkg::ST_LOOKBEHIND;
						end else if (sm_len > room) begin
							n_sticky = lzo_pkg::ST_OVERRUN;
						end else begin
							n_md = sm_dist[15:0];
							n_run = sm_len;
							n_trail = sm_tr;
							n_ph = lzo_pkg::PH_COPY;
						end
					end
				end
			end else if (ph_q == lzo_pkg::PH_COPY) begin
				put = 1'b1;
				copy = 1'b1;
				n_run = run_q - 24'd1;
				if (n_run == 24'd0) begin
					if (trail_q == 2'd0) n_ph = lzo_pkg::PH_TOP;
					else if (24'(trail_q) > room_p) n_sticky = lzo_pkg::ST_OVERRUN;
					else n_ph = lzo_pkg::PH_TRAIL;
				end
			end
		end
		if (put) begin
			n_oc = oc_q + 24'd1;
			n_wr = (wr_q == AW'(WINDOW_BYTES - 1)) ? '0 : wr_q + 1'b1;
		end
	end

	always_comb begin
		cmd.put = put;
		cmd.copy = copy;
		cmd.data = (put && !copy) ? b : 8'd0;
		cmd.copy_pending = (n_sticky == lzo_pkg::ST_OK) && (n_ph == lzo_pkg::PH_COPY);
		cmd.finished = (n_sticky == lzo_pkg::ST_OK) && (n_ph == lzo_pkg::PH_DONE);
		cmd.status = refused ? lzo_pkg::ST_REFUSED : n_sticky;
		cmd.consumed = n_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= lzo_pkg::PH_FIRST;
			sticky_q <= lzo_pkg::ST_OK;
			oc_q <= '0; in_q <= '0; run_q <= '0; md_q <= '0;
			trail_q <= '0; instr_q <= '0; wr_q <= '0;
		end else if (q_push) begin
			ph_q <= n_ph; sticky_q <= n_sticky; oc_q <= n_oc; in_q <= n_in;
			run_q <= n_run; md_q <= n_md; trail_q <= n_trail; instr_q <= n_instr;
			wr_q <= n_wr;
		end
	end

endmodule

// File: sv/lzo_queue.sv
// ----------------------------------------------------------------------------
// LZO1X command queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lzo_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lzo_pkg::QUEUE_DEPTH,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             nempty,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full   = (cnt_q == (PW+1)'(DEPTH));
	assign nempty = (cnt_q != '0);
	assign dout   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

// File: sv/lzo_back.sv
// ----------------------------------------------------------------------------
// LZO1X back end
// Reads history for copies, writes decoded bytes, drives the result channel.
// ----------------------------------------------------------------------------
module lzo_back #(
	parameter int WINDOW_BYTES = lzo_pkg::WINDOW_BYTES_DEF,
	localparam int AW = $clog2(WINDOW_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nempty,
	output logic          q_pop,
	input  lzo_pkg::cmd_t q_cmd,
	input  logic [AW-1:0] q_src,
	input  logic [AW-1:0] q_wa,
	lzo_out_if.source     out_ch
);

	lzo_pkg::cmd_t cmd_s2;
	logic [AW-1:0] src_s2, wa_s2, raddr;
	logic          v_s2, adv, we, fwd_q;
	logic [7:0]    rdata, fwd_d_q, byte_s2;

	assign adv   = !v_s2 || out_ch.ready;
	assign q_pop = adv && q_nempty;
	assign raddr = adv ? q_src : src_s2;
	assign we    = v_s2 && out_ch.ready && cmd_s2.put;
	assign byte_s2 = cmd_s2.copy ? (fwd_q ? fwd_d_q : rdata) : cmd_s2.data;

	lzo_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (wa_s2),
		.wdata (byte_s2),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_ch.valid        = v_s2;
	assign out_ch.out_valid    = cmd_s2.put;
	assign out_ch.out_byte     = byte_s2;
	assign out_ch.copy_pending = cmd_s2.copy_pending;
	assign out_ch.finished     = cmd_s2.finished;
	assign out_ch.status       = cmd_s2.status;
	assign out_ch.consumed     = cmd_s2.consumed;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= q_cmd;
			src_s2 <= q_src;
			wa_s2 <= q_wa;
		end
		fwd_d_q <= byte_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			if (adv) v_s2 <= q_nempty;
			// forward a byte written in the same cycle as its read
			fwd_q <= we && (raddr == wa_s2);
		end
	end

endmodule

// File: sv/lzo1x_stream_decompressor_core.sv
// ----------------------------------------------------------------------------
// LZO1X stream decompressor core
// Usage: in_ch carries one word per item: opcode 0 feeds a compressed byte,
// opcode 1 pulls the next match byte. Every accepted word yields exactly one
// result word on out_ch with the decoded byte (if any), copy_pending,
// finished, status and the count of consumed bytes.
// cfg_we/cfg_wdata set the expected output size; write it while idle.
// Throughput is one word per cycle on both sides while out_ch.ready is high.
// An accepted word passes the command queue and the back-end stage register;
// the front end decodes combinationally, the back end reads the registered
// history RAM, and a forwarding register covers a copy distance of one.
// A four-entry command queue separates the sides; when the receiver stalls
// the queue fills and in_ch.ready drops once it is full.
// Reset clears the parser, counters and status; the history RAM is not
// cleared and needs no sweep, since no copy may reach unwritten bytes.
// ----------------------------------------------------------------------------
module lzo1x_stream_decompressor_core #(
	parameter int WINDOW_BYTES = lzo_pkg::WINDOW_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lzo_in_if.sink      in_ch,
	lzo_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata
);

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int QW = lzo_pkg::CMD_W + 2 * AW;

	logic [23:0]   out_limit_q;
	logic          q_push, q_full, q_pop, q_nempty;
	lzo_pkg::cmd_t f_cmd, b_cmd;
	logic [AW-1:0] f_src, f_wa, b_src, b_wa;
	logic [QW-1:0] q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= '0;
		end else if (cfg_we) begin
			out_limit_q <= cfg_wdata;
		end
	end

	lzo_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_limit (out_limit_q),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.q_push    (q_push),
		.cmd       (f_cmd),
		.src       (f_src),
		.wa        (f_wa)
	);

	lzo_queue #(.WIDTH(QW), .DEPTH(lzo_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({f_cmd, f_src, f_wa}),
		.full   (q_full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.dout   (q_dout)
	);

	assign {b_cmd, b_src, b_wa} = q_dout;

	lzo_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_nempty (q_nempty),
		.q_pop    (q_pop),
		.q_cmd    (b_cmd),
		.q_src    (b_src),
		.q_wa     (b_wa),
		.out_ch   (out_ch)
	);

	a_done_not_copy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.copy_pending && out_ch.finished))
		else $error("finished and copy_pending together");

	a_refused_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == lzo_pkg::ST_REFUSED) |-> !out_ch.out_valid)
		else $error("refused word produced a byte");

	a_finished_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.finished) |-> out_ch.status == lzo_pkg::ST_OK)
		else $error("finished with error status");

	a_ready_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> q_nempty)
		else $error("input stalled with empty queue");

endmodule
